FILE: rtl/fpr_pkg.sv
`default_nettype none
package fpr_pkg;

    localparam int DEF_SCREEN_WIDTH  = 800;
    localparam int DEF_SCREEN_HEIGHT = 480;
    localparam int WORD_W = 32;
    localparam int CW     = 16;
    localparam int RAD_W  = 10;
    localparam int SQ_W   = 2 * RAD_W;

    typedef logic signed [CW-1:0] coord_t;

    typedef enum logic [2:0] {
        ACT_CLEAR  = 3'd0,
        ACT_PIXEL  = 3'd1,
        ACT_FRECT  = 3'd2,
        ACT_ORECT  = 3'd3,
        ACT_FROUND = 3'd4,
        ACT_OROUND = 3'd5,
        ACT_CIRCLE = 3'd6,
        ACT_READ   = 3'd7
    } act_t;

    typedef enum logic [3:0] {
        T_IDLE, T_FIX, T_FIXW, T_SQ, T_ROOT, T_ROOTW, T_COR, T_CORW, T_RD, T_RDW
    } top_state_t;

    typedef enum logic [2:0] {
        SP_CLR, SP_IDLE, SP_BASE, SP_RUN, SP_RBASE, SP_RMEM, SP_ROUT
    } span_state_t;

    typedef struct packed {
        logic   op_rect;
        logic   op_read;
        coord_t x;
        coord_t y;
        coord_t w;
        coord_t h;
        logic   ink;
    } span_req_t;

    typedef struct packed {
        logic busy;
        logic rd_valid;
        logic rd_bit;
    } span_sts_t;

endpackage
`default_nettype wire

FILE: rtl/fpr_sqrt.sv
`default_nettype none
module fpr_sqrt
    import fpr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [SQ_W-1:0]  value,
    output logic                  done,
    output logic [RAD_W-1:0]      root,
    output logic [RAD_W:0]        rem
);

    localparam int CNT_W = $clog2(RAD_W);

    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [SQ_W-1:0]      acc_reg;
    logic [RAD_W-1:0]     root_reg, root_next;
    logic [RAD_W:0]       rem_reg, rem_next;
    logic [RAD_W+2:0]     cur;
    logic [RAD_W+2:0]     trial;
    logic                 ge;

    // One result bit per cycle: bring down two radicand bits, try root*4+1.
    always_comb
    begin
        cur       = {rem_reg, acc_reg[SQ_W-1:SQ_W-2]};
        trial     = {1'b0, root_reg, 2'b01};
        ge        = cur >= trial;
        rem_next  = ge ? (RAD_W+1)'(cur - trial) : (RAD_W+1)'(cur);
        root_next = {root_reg[RAD_W-2:0], ge};
        run_next  = run_reg ? (cnt_reg != CNT_W'(RAD_W - 1)) : start;
        done_next = run_reg && (cnt_reg == CNT_W'(RAD_W - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!run_reg && start)
        begin
            acc_reg  <= value;
            root_reg <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            acc_reg  <= {acc_reg[SQ_W-3:0], 2'b00};
            root_reg <= root_next;
            rem_reg  <= rem_next;
            cnt_reg  <= cnt_reg + CNT_W'(1);
        end
    end

    assign done = done_reg;
    assign root = root_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

FILE: rtl/fpr_span.sv
`default_nettype none
module fpr_span
    import fpr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire span_req_t req,
    output span_sts_t      sts
);

    localparam int WPR   = (SCREEN_WIDTH + WORD_W - 1) / WORD_W;
    localparam int DEPTH = WPR * SCREEN_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = ($clog2(SCREEN_WIDTH) > 5) ? $clog2(SCREEN_WIDTH) : 6;
    localparam int YW    = $clog2(SCREEN_HEIGHT);
    localparam int WIW   = XW - 5;

    span_state_t        state_reg, state_next;
    logic [AW-1:0]      clr_reg;
    logic [XW-1:0]      x0_reg, x1m_reg;
    logic [YW-1:0]      yc_reg, ye_reg;
    logic [AW-1:0]      base_reg;
    logic [WIW-1:0]     wi_reg;
    logic               ink_reg;
    logic               off_reg;
    logic [WORD_W-1:0]  rdata_reg;
    logic [WORD_W-1:0]  mem [DEPTH];

    coord_t             cx0, cx1, cy0, cy1, cxe, cye;
    logic               empty;
    logic               offscreen;
    logic [WIW-1:0]     ws, we_idx;
    logic [4:0]         lo, hi;
    logic [WORD_W-1:0]  wmask;
    logic               wen;
    logic               wbit;
    logic [AW-1:0]      addr;
    logic               row_end;

    always_comb
    begin
        cxe = req.x + req.w;
        cye = req.y + req.h;
        cx0 = (req.x < 0) ? coord_t'(0) : req.x;
        cy0 = (req.y < 0) ? coord_t'(0) : req.y;
        cx1 = (cxe > coord_t'(SCREEN_WIDTH)) ? coord_t'(SCREEN_WIDTH) : cxe;
        cy1 = (cye > coord_t'(SCREEN_HEIGHT)) ? coord_t'(SCREEN_HEIGHT) : cye;
        empty = (req.w <= 0) || (req.h <= 0) || (cx0 >= cx1) || (cy0 >= cy1);
        offscreen = (req.x < 0) || (req.y < 0) || (req.x >= coord_t'(SCREEN_WIDTH))
                    || (req.y >= coord_t'(SCREEN_HEIGHT));
    end

    // Bit mask of the current word inside the clipped run [x0, x1m].
    always_comb
    begin
        ws     = x0_reg[XW-1:5];
        we_idx = x1m_reg[XW-1:5];
        lo     = (wi_reg == ws) ? x0_reg[4:0] : 5'd0;
        hi     = (wi_reg == we_idx) ? x1m_reg[4:0] : 5'd31;
        for (int i = 0; i < WORD_W; i++)
        begin
            wmask[i] = (5'(i) >= lo) && (5'(i) <= hi);
        end
        row_end = (wi_reg == we_idx);
        if (state_reg == SP_CLR)
            addr = clr_reg;
        else if (state_reg == SP_RMEM)
            addr = base_reg + AW'(x0_reg[XW-1:5]);
        else
            addr = base_reg + AW'(wi_reg);
        wen  = (state_reg == SP_CLR) || (state_reg == SP_RUN);
        wbit = (state_reg == SP_CLR) ? 1'b0 : ink_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SP_CLR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = SP_IDLE;
            end
            SP_IDLE:
            begin
                if (req.op_read)
                    state_next = offscreen ? SP_ROUT : SP_RBASE;
                else if (req.op_rect && !empty)
                    state_next = SP_BASE;
            end
            SP_BASE:  state_next = SP_RUN;
            SP_RUN:
            begin
                if (row_end && (yc_reg == ye_reg))
                    state_next = SP_IDLE;
            end
            SP_RBASE: state_next = SP_RMEM;
            SP_RMEM:  state_next = SP_ROUT;
            SP_ROUT:  state_next = SP_IDLE;
            default:  state_next = SP_IDLE;
        endcase
    end

    always_comb
    begin
        sts.busy     = (state_reg != SP_IDLE);
        sts.rd_valid = (state_reg == SP_ROUT);
        sts.rd_bit   = !off_reg && rdata_reg[x0_reg[4:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SP_CLR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == SP_CLR)
                clr_reg <= clr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            SP_IDLE:
            begin
                ink_reg <= req.ink;
                off_reg <= offscreen;
                if (req.op_read)
                begin
                    x0_reg <= XW'(req.x);
                    yc_reg <= YW'(req.y);
                end
                else
                begin
                    x0_reg  <= XW'(cx0);
                    x1m_reg <= XW'(cx1 - coord_t'(1));
                    yc_reg  <= YW'(cy0);
                    ye_reg  <= YW'(cy1 - coord_t'(1));
                    wi_reg  <= cx0[XW-1:5];
                end
            end
            SP_BASE, SP_RBASE:
            begin
                base_reg <= AW'(yc_reg) * AW'(WPR);
            end
            SP_RUN:
            begin
                if (row_end)
                begin
                    wi_reg   <= ws;
                    yc_reg   <= yc_reg + YW'(1);
                    base_reg <= base_reg + AW'(WPR);
                end
                else
                begin
                    wi_reg <= wi_reg + WIW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            for (int i = 0; i < WORD_W; i++)
            begin
                if ((state_reg == SP_CLR) || wmask[i])
                    mem[addr][i] <= wbit;
            end
        end
        if (state_reg == SP_RMEM)
            rdata_reg <= mem[addr];
    end

`ifndef ASSERT_OFF
    a_run_in_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SP_RUN) |-> (yc_reg <= ye_reg))
        else $error("span row past its last row");
    a_run_in_words: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SP_RUN) |-> (wi_reg <= we_idx) && (x0_reg <= x1m_reg))
        else $error("span word past its last word");
    a_rout_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SP_RMEM) |=> (state_reg == SP_ROUT))
        else $error("read did not deliver after memory access");
`endif

endmodule
`default_nettype wire

FILE: rtl/mono_framebuffer_primitive_raster.sv
`default_nettype none
// Monochrome rasterizer over a 1-bit frame memory of SCREEN_WIDTH x SCREEN_HEIGHT.
// A command is taken at a clock edge where start is high and busy is low; busy
// stays high until every pixel of the command is written. Read pixel (action 7)
// gives one result: valid is high for exactly one cycle with pixel_value; it comes
// sooner for an off-screen point, which skips the span unit's row-base and
// memory-read steps. The receiver cannot stall that strobe.
// The frame is held as 32-bit words, row-major, WPR = ceil(width/32) words per
// row. Each rectangle is issued, its row base is set, and its words are then
// written one by one along each row; a full clear writes all SCREEN_HEIGHT * WPR
// words. Rounded and circle commands run the iterative square root, which yields
// one root bit per cycle, once per corner row, and add the word writes of each
// short run.
// After reset the block sweeps the memory to black, one word per cycle, over all
// SCREEN_HEIGHT * WPR words; busy is high meanwhile.
module mono_framebuffer_primitive_raster
    import fpr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         action,
    input  wire logic signed [12:0] pos_x,
    input  wire logic signed [12:0] pos_y,
    input  wire logic signed [12:0] span_w,
    input  wire logic signed [12:0] span_h,
    input  wire logic [9:0]         radius,
    input  wire logic               ink,
    output logic                    valid,
    output logic                    pixel_value
);

    top_state_t          state_reg, state_next;
    act_t                act_reg;
    coord_t              x_reg, y_reg, w_reg, h_reg;
    logic [RAD_W-1:0]    r_reg;
    logic                ink_reg;
    logic [SQ_W-1:0]     r2_reg, yy2_reg;
    logic [1:0]          k_reg;
    logic signed [11:0]  yy_reg;
    logic [RAD_W-1:0]    flo_reg;
    logic [RAD_W:0]      rnd_reg;

    span_req_t           req;
    span_sts_t           sts;
    logic                sq_start, sq_done;
    logic [RAD_W-1:0]    sq_root;
    logic [RAD_W:0]      sq_rem;

    logic [1:0]          fix_last, cor_last;
    logic                has_loop;
    logic signed [11:0]  yy_end;
    logic [RAD_W-1:0]    yy_abs;
    coord_t              rx, ry, rw, rh, cr, cyy, cxm, cd, xa, xb, ya, yb;
    logic [RAD_W-1:0]    xm;

    fpr_span #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_span (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .sts   (sts)
    );

    fpr_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (r2_reg - yy2_reg),
        .done  (sq_done),
        .root  (sq_root),
        .rem   (sq_rem)
    );

    // Per-command shape: how many fixed runs, and whether a corner loop follows.
    always_comb
    begin
        fix_last = 2'd0;
        cor_last = 2'd3;
        has_loop = 1'b0;
        yy_end   = 12'(r_reg) - 12'sd1;
        case (act_reg)
            ACT_ORECT:  fix_last = 2'd3;
            ACT_FROUND:
            begin
                fix_last = 2'd2;
                has_loop = (r_reg != '0);
            end
            ACT_OROUND:
            begin
                fix_last = 2'd3;
                has_loop = (r_reg != '0);
            end
            ACT_CIRCLE:
            begin
                has_loop = 1'b1;
                cor_last = 2'd0;
                yy_end   = 12'(r_reg);
            end
            default:
            begin
            end
        endcase
        yy_abs = yy_reg[11] ? RAD_W'(-yy_reg) : RAD_W'(yy_reg);
    end

    // Run generator: the rectangle for step k of the fixed list or of a corner row.
    always_comb
    begin
        cr  = coord_t'(r_reg);
        cyy = coord_t'(yy_reg);
        xm  = (flo_reg > r_reg - RAD_W'(1)) ? r_reg - RAD_W'(1) : flo_reg;
        cxm = coord_t'(xm);
        cd  = coord_t'(rnd_reg);
        ya  = y_reg + cr - coord_t'(1) - cyy;
        yb  = y_reg + h_reg - cr + cyy;
        xa  = x_reg + cr - coord_t'(1) - cxm;
        xb  = x_reg + w_reg - cr;
        rx  = x_reg;
        ry  = y_reg;
        rw  = w_reg;
        rh  = h_reg;
        if (state_reg == T_COR)
        begin
            rh = coord_t'(1);
            case (act_reg)
                ACT_FROUND:
                begin
                    rx = k_reg[0] ? xb : xa;
                    ry = k_reg[1] ? yb : ya;
                    rw = cxm + coord_t'(1);
                end
                ACT_OROUND:
                begin
                    rx = k_reg[0] ? (x_reg + w_reg - coord_t'(1) - cr + cd) : (x_reg + cr - cd);
                    ry = k_reg[1] ? yb : ya;
                    rw = coord_t'(1);
                end
                default:
                begin
                    rx = x_reg - cd;
                    ry = y_reg + cyy;
                    rw = (cd <<< 1) + coord_t'(1);
                end
            endcase
        end
        else
        begin
            case (act_reg)
                ACT_CLEAR:
                begin
                    rx = '0;
                    ry = '0;
                    rw = coord_t'(SCREEN_WIDTH);
                    rh = coord_t'(SCREEN_HEIGHT);
                end
                ACT_PIXEL:
                begin
                    rw = coord_t'(1);
                    rh = coord_t'(1);
                end
                ACT_ORECT:
                begin
                    case (k_reg)
                        2'd0: rh = coord_t'(1);
                        2'd1:
                        begin
                            ry = y_reg + h_reg - coord_t'(1);
                            rh = coord_t'(1);
                        end
                        2'd2: rw = coord_t'(1);
                        default:
                        begin
                            rx = x_reg + w_reg - coord_t'(1);
                            rw = coord_t'(1);
                        end
                    endcase
                end
                ACT_FROUND:
                begin
                    case (k_reg)
                        2'd0:
                        begin
                            rx = x_reg + cr;
                            rw = w_reg - (cr <<< 1);
                        end
                        2'd1:
                        begin
                            ry = y_reg + cr;
                            rw = cr;
                            rh = h_reg - (cr <<< 1);
                        end
                        default:
                        begin
                            rx = x_reg + w_reg - cr;
                            ry = y_reg + cr;
                            rw = cr;
                            rh = h_reg - (cr <<< 1);
                        end
                    endcase
                end
                ACT_OROUND:
                begin
                    case (k_reg)
                        2'd0:
                        begin
                            rx = x_reg + cr;
                            rw = w_reg - (cr <<< 1);
                            rh = coord_t'(1);
                        end
                        2'd1:
                        begin
                            rx = x_reg + cr;
                            ry = y_reg + h_reg - coord_t'(1);
                            rw = w_reg - (cr <<< 1);
                            rh = coord_t'(1);
                        end
                        2'd2:
                        begin
                            ry = y_reg + cr;
                            rw = coord_t'(1);
                            rh = h_reg - (cr <<< 1);
                        end
                        default:
                        begin
                            rx = x_reg + w_reg - coord_t'(1);
                            ry = y_reg + cr;
                            rw = coord_t'(1);
                            rh = h_reg - (cr <<< 1);
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (start && !sts.busy)
                begin
                    if (act_t'(action) == ACT_READ)
                        state_next = T_RD;
                    else if (act_t'(action) == ACT_CIRCLE)
                        state_next = T_SQ;
                    else
                        state_next = T_FIX;
                end
            end
            T_FIX:  state_next = T_FIXW;
            T_FIXW:
            begin
                if (!sts.busy)
                begin
                    if (k_reg != fix_last)
                        state_next = T_FIX;
                    else
                        state_next = has_loop ? T_SQ : T_IDLE;
                end
            end
            T_SQ:    state_next = T_ROOT;
            T_ROOT:  state_next = T_ROOTW;
            T_ROOTW:
            begin
                if (sq_done)
                    state_next = T_COR;
            end
            T_COR:   state_next = T_CORW;
            T_CORW:
            begin
                if (!sts.busy)
                begin
                    if (k_reg != cor_last)
                        state_next = T_COR;
                    else
                        state_next = (yy_reg == yy_end) ? T_IDLE : T_SQ;
                end
            end
            T_RD:    state_next = T_RDW;
            T_RDW:
            begin
                if (sts.rd_valid)
                    state_next = T_IDLE;
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_comb
    begin
        req.op_rect = (state_reg == T_FIX) || (state_reg == T_COR);
        req.op_read = (state_reg == T_RD);
        req.x       = rx;
        req.y       = ry;
        req.w       = rw;
        req.h       = rh;
        req.ink     = ink_reg;
        sq_start    = (state_reg == T_ROOT);
        busy        = (state_reg != T_IDLE) || sts.busy;
        valid       = sts.rd_valid;
        pixel_value = sts.rd_bit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= T_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            T_IDLE:
            begin
                act_reg <= act_t'(action);
                x_reg   <= coord_t'(pos_x);
                y_reg   <= coord_t'(pos_y);
                w_reg   <= coord_t'(span_w);
                h_reg   <= coord_t'(span_h);
                r_reg   <= radius;
                ink_reg <= ink;
                r2_reg  <= radius * radius;
                k_reg   <= 2'd0;
                yy_reg  <= (act_t'(action) == ACT_CIRCLE) ? -$signed(12'(radius)) : 12'sd0;
            end
            T_FIXW:
            begin
                if (!sts.busy)
                    k_reg <= (k_reg == fix_last) ? 2'd0 : k_reg + 2'd1;
            end
            T_SQ:
            begin
                yy2_reg <= yy_abs * yy_abs;
            end
            T_ROOTW:
            begin
                if (sq_done)
                begin
                    flo_reg <= sq_root;
                    rnd_reg <= (RAD_W+1)'(sq_root) + (RAD_W+1)'(sq_rem > (RAD_W+1)'(sq_root));
                end
            end
            T_CORW:
            begin
                if (!sts.busy)
                begin
                    if (k_reg == cor_last)
                    begin
                        k_reg  <= 2'd0;
                        yy_reg <= yy_reg + 12'sd1;
                    end
                    else
                    begin
                        k_reg <= k_reg + 2'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_valid_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (state_reg == T_RDW))
        else $error("result strobe outside a read");
    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not raise busy");
    a_issue_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (req.op_rect || req.op_read) |-> !sts.busy)
        else $error("run issued while span unit busy");
    a_root_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_COR) |-> (rnd_reg <= (RAD_W+1)'(r_reg)))
        else $error("corner root above radius");
`endif

endmodule
`default_nettype wire
